// File: rtl/core/lsab_pkg.sv
package lsab_pkg;

	// Field widths of one node and one result.
	localparam int unsigned ANGLE_W = 16;
	localparam int unsigned DIST_W  = 32;
	localparam int unsigned QUAL_W  = 8;
	localparam int unsigned MM_W    = 16;
	localparam int unsigned DEG_W   = 9;
	localparam int unsigned CHUNK_W = 6;

	// Bin store: one entry per whole degree, 0..360.
	localparam int unsigned STORE_DEPTH = 361;
	localparam int unsigned ADDR_W      = 9;

	// Result lanes.
	localparam int unsigned MAX_LANES = 8;
	localparam int unsigned LANE_W    = 3;

	// Angle conversion: (angle * 90 + 8192) >> 14.
	localparam int unsigned SCALED_W  = 23;
	localparam logic [SCALED_W-1:0] DEG_SCALE = 23'd90;
	localparam logic [SCALED_W-1:0] DEG_ROUND = 23'd8192;
	localparam int unsigned DEG_SHIFT = 14;

	// Rounded mean (2*sum + count) / (2*count).
	localparam int unsigned NUM_W = 18;
	localparam int unsigned DEN_W = 17;
	localparam int unsigned STEP_W = 5;

	// Queue between the front and the back.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;
	localparam int unsigned QCNT_W      = 3;

	typedef struct packed {
		logic [DEG_W-1:0] degree;
		logic [MM_W-1:0]  mm;
		logic             valid;
		logic             sync;
	} node_t;

	typedef logic [MAX_LANES-1:0][MM_W-1:0] lanes_t;

endpackage

// File: rtl/core/lidar_scan_angle_binner_unit.sv
// Each node's rounded mean is formed by the 18-step serial divider and written to
// its bin; the back end takes no new node until then, or after a sync node until
// its frame is out, and a four-entry queue lets the input keep taking nodes meanwhile.
// A sync node reads the store through its single read port: a read state and a
// capture state per bin, a hand-off state per result that waits on m_axis_tready.
// After reset all 361 bin store entries are cleared with s_axis_tready low.
module lidar_scan_angle_binner_unit #(
	parameter int unsigned BIN_COUNT       = 360,
	parameter int unsigned BINS_PER_RESULT = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [55:0]  s_axis_tdata,   // angle_q14[15:0], dist_q2[47:16], quality[55:48]
	input  logic         s_axis_tuser,   // sync
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,   // dist0[15:0], dist1 .. dist7[127:112]
	output logic [5:0]   m_axis_tuser,   // chunk_index
	output logic         m_axis_tlast    // last
);

	logic             clearing;
	logic             push_valid;
	logic             push_ready;
	lsab_pkg::node_t  push_node;
	logic             pop_valid;
	logic             pop_ready;
	lsab_pkg::node_t  pop_node;
	lsab_pkg::lanes_t out_dist;

	lsab_front u_front (
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.angle_q14  (s_axis_tdata[15:0]),
		.dist_q2    (s_axis_tdata[47:16]),
		.quality    (s_axis_tdata[55:48]),
		.sync       (s_axis_tuser),
		.clearing   (clearing),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_node  (push_node)
	);

	lsab_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_node  (push_node),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_node   (pop_node)
	);

	lsab_back #(
		.BIN_COUNT       (BIN_COUNT),
		.BINS_PER_RESULT (BINS_PER_RESULT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_node  (pop_node),
		.clearing  (clearing),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_chunk (m_axis_tuser),
		.out_dist  (out_dist),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = out_dist;

endmodule

// File: rtl/core/lsab_front.sv
module lsab_front (
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lsab_pkg::ANGLE_W-1:0]  angle_q14,
	input  logic [lsab_pkg::DIST_W-1:0]   dist_q2,
	input  logic [lsab_pkg::QUAL_W-1:0]   quality,
	input  logic                          sync,
	input  logic                          clearing,
	input  logic                          push_ready,
	output logic                          push_valid,
	output lsab_pkg::node_t               push_node
);

	logic [lsab_pkg::SCALED_W-1:0] scaled;

	assign scaled = lsab_pkg::SCALED_W'(angle_q14) * lsab_pkg::DEG_SCALE + lsab_pkg::DEG_ROUND;

	always_comb begin
		push_node.degree = scaled[lsab_pkg::SCALED_W-1:lsab_pkg::DEG_SHIFT];
		// Millimetres are the raw value over four; anything past 16 bits clamps.
		push_node.mm     = (|dist_q2[lsab_pkg::DIST_W-1:lsab_pkg::MM_W+2]) ?
			{lsab_pkg::MM_W{1'b1}} : dist_q2[lsab_pkg::MM_W+1:2];
		push_node.valid  = (quality != '0);
		push_node.sync   = sync;
	end

	// No transfer is taken while the bin store is being cleared.
	assign in_ready   = push_ready && !clearing;
	assign push_valid = in_valid && !clearing;

endmodule

// File: rtl/core/lsab_queue.sv
module lsab_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  lsab_pkg::node_t push_node,
	output logic            pop_valid,
	input  logic            pop_ready,
	output lsab_pkg::node_t pop_node
);

	lsab_pkg::node_t                entries_q [lsab_pkg::QUEUE_DEPTH];
	logic [lsab_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [lsab_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [lsab_pkg::QCNT_W-1:0]    count_q;
	logic                           do_push;
	logic                           do_pop;

	assign push_ready = (count_q != lsab_pkg::QCNT_W'(lsab_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_node   = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			entries_q[wr_ptr_q] <= push_node;
	end

endmodule

// File: rtl/core/lsab_div.sv
module lsab_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lsab_pkg::NUM_W-1:0]  num,
	input  logic [lsab_pkg::DEN_W-1:0]  den,
	output logic                        done,
	output logic [lsab_pkg::MM_W-1:0]   quot
);

	localparam logic [lsab_pkg::STEP_W-1:0] STEPS = lsab_pkg::STEP_W'(lsab_pkg::NUM_W);

	logic [lsab_pkg::NUM_W-1:0]  num_q;
	logic [lsab_pkg::DEN_W-1:0]  rem_q;
	logic [lsab_pkg::DEN_W-1:0]  den_q;
	logic [lsab_pkg::STEP_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [lsab_pkg::NUM_W:0]    diff;
	logic                        fits;
	logic [lsab_pkg::DEN_W-1:0]  rem_next;

	// One restoring step per cycle; quotient bits shift in behind the dividend.
	always_comb begin
		diff     = {1'b0, rem_q, num_q[lsab_pkg::NUM_W-1]} - {2'b00, den_q};
		fits     = !diff[lsab_pkg::NUM_W];
		rem_next = fits ? diff[lsab_pkg::DEN_W-1:0] :
			{rem_q[lsab_pkg::DEN_W-2:0], num_q[lsab_pkg::NUM_W-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= STEPS;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == lsab_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[lsab_pkg::NUM_W-2:0], fits};
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign quot = num_q[lsab_pkg::MM_W-1:0];

endmodule

// File: rtl/core/lsab_back.sv
module lsab_back #(
	parameter int unsigned BIN_COUNT       = 360,
	parameter int unsigned BINS_PER_RESULT = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  lsab_pkg::node_t               pop_node,
	output logic                          clearing,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lsab_pkg::CHUNK_W-1:0]  out_chunk,
	output lsab_pkg::lanes_t              out_dist,
	output logic                          out_last
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_CAPT  = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	localparam logic [lsab_pkg::ADDR_W-1:0] LAST_BIN   = lsab_pkg::ADDR_W'(BIN_COUNT - 1);
	localparam logic [lsab_pkg::ADDR_W-1:0] CLEAR_LAST =
		lsab_pkg::ADDR_W'(lsab_pkg::STORE_DEPTH - 1);
	localparam logic [lsab_pkg::LANE_W-1:0] LAST_LANE  = lsab_pkg::LANE_W'(BINS_PER_RESULT - 1);

	logic [2:0]                       state_q;
	logic [lsab_pkg::ADDR_W-1:0]      addr_q;
	logic [lsab_pkg::DEG_W-1:0]       prev_q;
	logic [lsab_pkg::MM_W-1:0]        sum_q;
	logic [lsab_pkg::MM_W-1:0]        count_q;
	logic [lsab_pkg::DEG_W-1:0]       deg_q;
	logic                             sync_q;
	logic [lsab_pkg::LANE_W-1:0]      lane_q;
	logic [lsab_pkg::CHUNK_W-1:0]     chunk_q;
	logic                             last_chunk_q;
	lsab_pkg::lanes_t                 lanes_q;
	logic                             out_valid_q;
	logic [lsab_pkg::CHUNK_W-1:0]     out_chunk_q;
	lsab_pkg::lanes_t                 out_dist_q;
	logic                             out_last_q;
	logic [lsab_pkg::MM_W-1:0]        store_q [lsab_pkg::STORE_DEPTH];
	logic [lsab_pkg::MM_W-1:0]        rdata_q;

	logic                             cont;
	logic [lsab_pkg::MM_W-1:0]        sum_n;
	logic [lsab_pkg::MM_W-1:0]        count_n;
	logic                             div_start;
	logic                             div_done;
	logic [lsab_pkg::MM_W-1:0]        div_quot;
	logic [lsab_pkg::NUM_W-1:0]       div_num;
	logic [lsab_pkg::DEN_W-1:0]       div_den;
	logic                             mem_we;
	logic [lsab_pkg::ADDR_W-1:0]      mem_waddr;
	logic [lsab_pkg::MM_W-1:0]        mem_wdata;
	logic                             load_out;

	// Run tracking: a valid node on the same degree extends the running mean.
	always_comb begin
		cont    = (pop_node.degree == prev_q) && pop_node.valid;
		sum_n   = cont ? sum_q + pop_node.mm : pop_node.mm;
		count_n = !cont ? lsab_pkg::MM_W'(1) :
			((count_q == {lsab_pkg::MM_W{1'b1}}) ? count_q : count_q + 1'b1);
		div_num = {1'b0, sum_n, 1'b0} + {2'b00, count_n};
		div_den = {count_n, 1'b0};
	end

	assign pop_ready = (state_q == ST_IDLE);
	assign div_start = (state_q == ST_IDLE) && pop_valid;
	assign clearing  = (state_q == ST_CLEAR);
	assign load_out  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		mem_we    = (state_q == ST_CLEAR) || ((state_q == ST_DIV) && div_done);
		mem_waddr = (state_q == ST_CLEAR) ? addr_q : deg_q;
		mem_wdata = (state_q == ST_CLEAR) ? '0 : div_quot;
	end

	lsab_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk) begin
		if (mem_we)
			store_q[mem_waddr] <= mem_wdata;
		rdata_q <= store_q[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			addr_q       <= '0;
			prev_q       <= '0;
			sum_q        <= '0;
			count_q      <= lsab_pkg::MM_W'(1);
			deg_q        <= '0;
			sync_q       <= 1'b0;
			lane_q       <= '0;
			chunk_q      <= '0;
			last_chunk_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == CLEAR_LAST)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (pop_valid) begin
						prev_q  <= pop_node.degree;
						sum_q   <= sum_n;
						count_q <= count_n;
						deg_q   <= pop_node.degree;
						sync_q  <= pop_node.sync;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (sync_q) begin
							addr_q  <= LAST_BIN;
							lane_q  <= '0;
							chunk_q <= '0;
							state_q <= ST_READ;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_CAPT;
				end
				ST_CAPT: begin
					if ((lane_q == LAST_LANE) || (addr_q == '0)) begin
						last_chunk_q <= (addr_q == '0);
						state_q      <= ST_OUT;
					end else begin
						lane_q  <= lane_q + 1'b1;
						addr_q  <= addr_q - 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						if (last_chunk_q) begin
							state_q <= ST_IDLE;
						end else begin
							addr_q  <= addr_q - 1'b1;
							lane_q  <= '0;
							chunk_q <= chunk_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Lanes start at zero for every chunk so a short final chunk pads with zeros.
	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV) || load_out)
			lanes_q <= '0;
		else if (state_q == ST_CAPT)
			lanes_q[lane_q] <= rdata_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_chunk_q <= chunk_q;
			out_dist_q  <= lanes_q;
			out_last_q  <= last_chunk_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_chunk = out_chunk_q;
	assign out_dist  = out_dist_q;
	assign out_last  = out_last_q;

endmodule

// File: tb/lidar_scan_angle_binner_unit_tb.sv
`timescale 1ns / 1ps

module lidar_scan_angle_binner_unit_tb;

	localparam int unsigned NBINS        = 360;
	localparam int unsigned PER_RESULT   = 8;
	localparam int unsigned FRAME_CHUNKS = (NBINS + PER_RESULT - 1) / PER_RESULT;
	localparam int unsigned DIR_ROWS     = 21;
	localparam int unsigned RAND_NODES   = 210;
	localparam int unsigned HOLD_CYCLES  = 3000;
	localparam int unsigned CYCLE_LIMIT  = 600000;
	localparam int unsigned MAX_PRINTS   = 40;

	typedef struct packed {
		logic [lsab_pkg::ANGLE_W-1:0] angle;
		logic [lsab_pkg::DIST_W-1:0]  dist_raw;
		logic [lsab_pkg::QUAL_W-1:0]  qual;
		logic                         sync;
		logic                         known;    // exp_far holds a typed-in value
		logic [lsab_pkg::MM_W-1:0]    exp_far;  // bin 359, the first lane of the frame
	} node_row_t;

	typedef struct packed {
		logic [lsab_pkg::CHUNK_W-1:0] chunk;
		lsab_pkg::lanes_t             lanes;
		logic                         is_last;
	} chunk_exp_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [55:0]  s_axis_tdata = '0;    // angle_q14[15:0], dist_q2[47:16], quality[55:48]
	logic         s_axis_tuser = 1'b0;  // sync
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;         // dist0[15:0], dist1 .. dist7[127:112]
	logic [5:0]   m_axis_tuser;         // chunk_index
	logic         m_axis_tlast;

	// Shadow copy of the bin store and of the running average.
	logic [lsab_pkg::MM_W-1:0]  bin_mm [lsab_pkg::STORE_DEPTH];
	logic [lsab_pkg::DEG_W-1:0] run_deg;
	logic [lsab_pkg::MM_W-1:0]  run_total;
	logic [lsab_pkg::MM_W-1:0]  run_nodes;

	chunk_exp_t  pending_chunks [$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	bit          steady = 1'b0;
	bit          hold_req = 1'b0;
	bit          hold_taken = 1'b0;
	int unsigned hold_left = 0;

	node_row_t dir_nodes [DIR_ROWS] = '{
		// First node lands on degree 0 and extends the run left by reset.
		'{16'd0,     32'd400,        8'd10,  1'b1, 1'b1, 16'd0},
		'{16'd0,     32'd800,        8'd10,  1'b0, 1'b0, 16'd0},
		'{16'd0,     32'd1200,       8'd0,   1'b0, 1'b0, 16'd0},
		'{16'd91,    32'd4,          8'd7,   1'b0, 1'b0, 16'd0},
		'{16'd92,    32'd3,          8'd1,   1'b0, 1'b0, 16'd0},
		'{16'd92,    32'h0003_FFFC,  8'd255, 1'b0, 1'b0, 16'd0},
		'{16'd92,    32'h0003_FFFF,  8'd255, 1'b0, 1'b0, 16'd0},
		'{16'd92,    32'h0004_0000,  8'd128, 1'b0, 1'b0, 16'd0},
		// Degree 360 has its own bin, which the readout never shows.
		'{16'd65535, 32'hFFFF_FFFF,  8'd255, 1'b0, 1'b0, 16'd0},
		'{16'd65535, 32'd1000,       8'd255, 1'b1, 1'b0, 16'd0},
		'{16'd65263, 32'hFFFF_FFFF,  8'd255, 1'b1, 1'b1, 16'd65535},
		'{16'd32768, 32'h5555_5555,  8'hAA,  1'b0, 1'b0, 16'd0},
		'{16'd32768, 32'hAAAA_AAA8,  8'h55,  1'b0, 1'b0, 16'd0},
		'{16'd32768, 32'd40000,      8'h80,  1'b0, 1'b0, 16'd0},
		'{16'd16384, 32'd100000,     8'd1,   1'b0, 1'b0, 16'd0},
		'{16'd16384, 32'd100004,     8'd0,   1'b0, 1'b0, 16'd0},
		'{16'd182,   32'd2000,       8'd3,   1'b0, 1'b0, 16'd0},
		'{16'd8191,  32'd8000,       8'd9,   1'b0, 1'b0, 16'd0},
		'{16'd65262, 32'd36000,      8'd200, 1'b0, 1'b0, 16'd0},
		'{16'd65263, 32'd44000,      8'd1,   1'b1, 1'b0, 16'd0},
		'{16'h1234,  32'd0,          8'd0,   1'b1, 1'b0, 16'd0}
	};

	lidar_scan_angle_binner_unit #(
		.BIN_COUNT      (NBINS),
		.BINS_PER_RESULT(PER_RESULT)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("lidar_scan_angle_binner_unit_tb NOT OK");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < MAX_PRINTS)
			$display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// Folds one accepted node into the shadow store and queues the frame a sync node causes.
	function automatic void predict_node(input logic [lsab_pkg::ANGLE_W-1:0] angle,
			input logic [lsab_pkg::DIST_W-1:0] dist_raw,
			input logic [lsab_pkg::QUAL_W-1:0] qual, input logic sync);
		logic [lsab_pkg::SCALED_W-1:0] scaled;
		logic [lsab_pkg::DEG_W-1:0]    deg;
		logic [lsab_pkg::DIST_W-3:0]   mm_full;
		logic [lsab_pkg::MM_W-1:0]     mm;
		int unsigned                   num;
		int unsigned                   den;
		int unsigned                   pos;
		int unsigned                   c;
		int unsigned                   k;
		chunk_exp_t                    row;

		scaled = lsab_pkg::SCALED_W'(angle) * 23'd90 + 23'd8192;
		deg = scaled[lsab_pkg::SCALED_W-1 -: lsab_pkg::DEG_W];
		mm_full = dist_raw[lsab_pkg::DIST_W-1:2];
		mm = (mm_full > 65535) ? 16'hFFFF : mm_full[lsab_pkg::MM_W-1:0];

		if (deg == run_deg && qual != '0) begin
			run_total = run_total + mm;
			if (run_nodes != 16'hFFFF)
				run_nodes = run_nodes + 1'b1;
		end else begin
			run_total = mm;
			run_nodes = 16'd1;
		end
		run_deg = deg;
		num = 2 * run_total + run_nodes;
		den = 2 * run_nodes;
		bin_mm[deg] = lsab_pkg::MM_W'(num / den);

		if (sync) begin
			for (c = 0; c < FRAME_CHUNKS; c++) begin
				row.chunk = lsab_pkg::CHUNK_W'(c);
				row.is_last = (c == FRAME_CHUNKS - 1);
				for (k = 0; k < lsab_pkg::MAX_LANES; k++) begin
					pos = c * PER_RESULT + k;
					row.lanes[k] = (k < PER_RESULT && pos < NBINS) ?
						bin_mm[NBINS - 1 - pos] : '0;
				end
				pending_chunks.push_back(row);
			end
		end
	endfunction

	task automatic check_chunk();
		chunk_exp_t want;
		int         k;

		if (pending_chunks.size() == 0) begin
			report_mismatch("result with nothing pending, chunk_index", m_axis_tuser, -1);
		end else begin
			want = pending_chunks.pop_front();
			if (m_axis_tuser !== want.chunk)
				report_mismatch("chunk_index", m_axis_tuser, want.chunk);
			for (k = 0; k < lsab_pkg::MAX_LANES; k++) begin
				if (m_axis_tdata[k*lsab_pkg::MM_W +: lsab_pkg::MM_W] !== want.lanes[k])
					report_mismatch($sformatf("dist%0d of chunk %0d", k, want.chunk),
						m_axis_tdata[k*lsab_pkg::MM_W +: lsab_pkg::MM_W], want.lanes[k]);
			end
			if (m_axis_tlast !== want.is_last)
				report_mismatch($sformatf("last of chunk %0d", want.chunk),
					m_axis_tlast, want.is_last);
		end
	endtask

	task automatic send_node(input logic [lsab_pkg::ANGLE_W-1:0] angle,
			input logic [lsab_pkg::DIST_W-1:0] dist_raw,
			input logic [lsab_pkg::QUAL_W-1:0] qual, input logic sync);
		while (!steady && $urandom_range(99, 0) < 36) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {qual, dist_raw, angle};
		s_axis_tuser <= sync;
		do @(posedge clk); while (!s_axis_tready);
		predict_node(angle, dist_raw, qual, sync);
	endtask

	// Stops offering nodes until the last queued frame has fully come out.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_chunks.size() != 0);
	endtask

	initial begin : result_sink
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				check_chunk();
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= steady || $urandom_range(99, 0) >= 36;
			end
		end
	end

	initial begin : node_source
		int                           i;
		int                           first;
		int                           mode;
		logic [lsab_pkg::ANGLE_W-1:0] angle;
		logic [lsab_pkg::DIST_W-1:0]  dist_raw;
		logic [lsab_pkg::QUAL_W-1:0]  qual;
		logic                         sync;
		chunk_exp_t                   row;

		for (i = 0; i < lsab_pkg::STORE_DEPTH; i++)
			bin_mm[i] = '0;
		run_deg = '0;
		run_total = '0;
		run_nodes = 16'd1;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_ROWS; i++) begin
			send_node(dir_nodes[i].angle, dir_nodes[i].dist_raw, dir_nodes[i].qual,
				dir_nodes[i].sync);
			if (dir_nodes[i].sync && dir_nodes[i].known) begin
				first = pending_chunks.size() - FRAME_CHUNKS;
				row = pending_chunks[first];
				row.lanes[0] = dir_nodes[i].exp_far;
				pending_chunks[first] = row;
			end
		end

		// Mostly runs of nodes on one degree, broken by jumps and zero-quality nodes.
		angle = 16'($urandom_range(65535, 0));
		for (i = 0; i < RAND_NODES; i++) begin
			mode = $urandom_range(99, 0);
			if (mode < 65)
				angle = angle + 16'($urandom_range(40, 0)) - 16'd20;
			else if (mode < 92)
				angle = 16'($urandom_range(65535, 0));
			else
				angle = 16'(65263 + $urandom_range(272, 0));
			qual = ($urandom_range(9, 0) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
			dist_raw = ($urandom_range(7, 0) == 0) ? 32'($urandom) :
				32'($urandom_range(300000, 0));
			sync = ($urandom_range(13, 0) == 0);

			steady = (i >= 40 && i < 90);
			// Several frames pile up behind a stalled receiver and back up the input.
			if (i == 120)
				hold_req = 1'b1;
			if (i >= 120 && i < 126)
				sync = (i % 2 == 0);
			if (i == 170)
				drain_results();

			send_node(angle, dist_raw, qual, sync);
		end

		drain_results();
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("lidar_scan_angle_binner_unit_tb OK");
		else
			$display("lidar_scan_angle_binner_unit_tb NOT OK");
		$finish;
	end

endmodule

// File: files.f
rtl/core/lsab_pkg.sv
rtl/core/lsab_front.sv
rtl/core/lsab_queue.sv
rtl/core/lsab_div.sv
rtl/core/lsab_back.sv
rtl/core/lidar_scan_angle_binner_unit.sv
tb/lidar_scan_angle_binner_unit_tb.sv
